// File: src/gisd_pkg.sv
// Package for greedy_independent_set_by_degree: payload structs, controller states,
// degree width and the saturating degree add. No dependencies.
package gisd_pkg;

   localparam int ID_W   = 10;
   localparam int CNT_W  = 11;
   localparam int DEG_W  = 14;
   localparam logic [DEG_W-1:0] DEG_MAX = 14'd16383;

   typedef enum logic {
      FUNC_LOAD   = 1'b0,
      FUNC_FINISH = 1'b1
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [ID_W-1:0]   end_a;
      logic [ID_W-1:0]   end_b;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0]  set_size;
      logic              dropped_edges;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_A,
      ST_LD_B,
      ST_SCAN,
      ST_SWEEP,
      ST_DONE
   } state_type;

   function automatic logic [DEG_W-1:0] deg_add(logic [DEG_W-1:0] d, logic [1:0] inc);
      logic [DEG_W:0] sum;
      sum = {1'b0, d} + {{(DEG_W-1){1'b0}}, inc};
      return (sum > {1'b0, DEG_MAX}) ? DEG_MAX : sum[DEG_W-1:0];
   endfunction

endpackage

// File: src/gisd_out.sv
// Result output register for greedy_independent_set_by_degree.
// Holds one result until the rsp channel transfers it. Uses gisd_pkg.
module gisd_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gisd_pkg::rsp_type push_data,
   output logic             can_push,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gisd_pkg::rsp_type rsp_data
);
   import gisd_pkg::*;

   logic    full_ff, full_in;
   rsp_type data_ff;

   assign can_push  = !full_ff || !rsp_stall;
   assign rsp_valid = full_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      full_in = full_ff;
      if (push) begin
         full_in = 1'b1;
      end else if (!rsp_stall) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      if (push) begin
         data_ff <= push_data;
      end
   end

endmodule

// File: src/greedy_independent_set_by_degree.sv
// Top level of greedy_independent_set_by_degree: edge, degree and alive memories
// with the load / select / sweep / clear controller. Uses gisd_pkg and gisd_out.
//
//   channel | ports                          | moves
//   req     | req_valid req_stall req_data   | edge load or finish, one per transfer
//   rsp     | rsp_valid rsp_stall rsp_data   | set size and drop flag per finish
//   csr     | csr_wr_en csr_wr_data          | node_count write, any cycle
//
// Edge load: degree read in ST_IDLE, then one write per end in ST_LD_A and ST_LD_B; a self-loop skips ST_LD_B.
// Finish: each selection round scans the live nodes and sweeps the edge memory;
// rounds repeat until no node is alive, then the result waits for the output register,
// then a clear pass over all MAX_NODES entries follows.
// After reset the same clear pass runs; req_stall is high until
// it ends. Config writes are taken at all times.
module greedy_independent_set_by_degree #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gisd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gisd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [gisd_pkg::CNT_W-1:0] csr_wr_data
);
   import gisd_pkg::*;

   localparam int NIW = $clog2(MAX_NODES);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EFW = $clog2(MAX_EDGES + 1);
   localparam int CAP = (MAX_NODES > 2047) ? 2047 : MAX_NODES;

   logic [DEG_W-1:0]    deg_mem   [MAX_NODES];
   logic                alive_mem [MAX_NODES];
   logic [2*ID_W-1:0]   edge_mem  [MAX_EDGES];

   state_type           state_ff, state_in;
   logic [EFW-1:0]      fill_ff, fill_in;
   logic                drop_ff, drop_in;
   logic [CNT_W-1:0]    ncnt_ff;
   logic [ID_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [CNT_W-1:0]    pidx_ff, pidx_in;
   logic                found_ff, found_in;
   logic [CNT_W-1:0]    best_ff, best_in;
   logic [DEG_W-1:0]    bdeg_ff, bdeg_in;
   logic [CNT_W-1:0]    size_ff, size_in;
   logic [EFW-1:0]      ep_ff, ep_in;
   logic [NIW-1:0]      clr_ff, clr_in;

   logic                deg_we, deg_rea, deg_reb;
   logic [NIW-1:0]      deg_waddr, deg_raddr_a, deg_raddr_b;
   logic [DEG_W-1:0]    deg_wdata, deg_qa_ff, deg_qb_ff;
   logic                alive_we, alive_wdata, alive_re, alive_q_ff;
   logic [NIW-1:0]      alive_waddr, alive_raddr;
   logic                edge_we, edge_re;
   logic [EAW-1:0]      edge_waddr, edge_raddr;
   logic [2*ID_W-1:0]   edge_q_ff;

   logic [CNT_W-1:0]    live_cnt, scan_dec;
   logic                req_take, bad_edge, out_can, out_push;
   logic [CNT_W-1:0]    ea, eb;
   rsp_type             out_data;

   assign live_cnt  = (ncnt_ff > CNT_W'(CAP)) ? CNT_W'(CAP) : ncnt_ff;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign bad_edge  = ({1'b0, req_data.end_a} >= live_cnt) ||
                      ({1'b0, req_data.end_b} >= live_cnt) ||
                      (fill_ff == EFW'(MAX_EDGES));
   assign scan_dec  = scan_ff - CNT_W'(1);
   assign ea        = {1'b0, edge_q_ff[ID_W-1:0]};
   assign eb        = {1'b0, edge_q_ff[2*ID_W-1:ID_W]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == NIW'(MAX_NODES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.func == FUNC_FINISH) state_in = ST_SCAN;
               else if (!bad_edge) state_in = ST_LD_A;
            end
         end
         ST_LD_A: begin
            state_in = (a_ff == b_ff) ? ST_IDLE : ST_LD_B;
         end
         ST_LD_B: state_in = ST_IDLE;
         ST_SCAN: begin
            if (scan_ff == '0 && !pend_ff) state_in = found_ff ? ST_SWEEP : ST_DONE;
         end
         ST_SWEEP: begin
            if (ep_ff == fill_ff && !pend_ff) state_in = ST_SCAN;
         end
         ST_DONE: begin
            if (out_can) state_in = ST_CLEAR;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      fill_in = fill_ff;   drop_in = drop_ff;
      a_in = a_ff;         b_in = b_ff;
      scan_in = scan_ff;   pend_in = 1'b0;      pidx_in = pidx_ff;
      found_in = found_ff; best_in = best_ff;   bdeg_in = bdeg_ff;
      size_in = size_ff;   ep_in = ep_ff;       clr_in = clr_ff;
      deg_we = 1'b0;       deg_waddr = '0;      deg_wdata = '0;
      deg_rea = 1'b0;      deg_raddr_a = '0;
      deg_reb = 1'b0;      deg_raddr_b = '0;
      alive_we = 1'b0;     alive_waddr = '0;    alive_wdata = 1'b0;
      alive_re = 1'b0;     alive_raddr = '0;
      edge_we = 1'b0;      edge_waddr = '0;
      edge_re = 1'b0;      edge_raddr = '0;
      out_push = 1'b0;
      out_data.set_size = size_ff;
      out_data.dropped_edges = drop_ff;
      case (state_ff)
         ST_CLEAR: begin
            deg_we = 1'b1;      deg_waddr = clr_ff;   deg_wdata = '0;
            alive_we = 1'b1;    alive_waddr = clr_ff; alive_wdata = 1'b1;
            clr_in = clr_ff + NIW'(1);
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.func == FUNC_FINISH) begin
                  scan_in = live_cnt;
                  found_in = 1'b0;
                  size_in = '0;
               end else if (bad_edge) begin
                  drop_in = 1'b1;
               end else begin
                  edge_we = 1'b1;
                  edge_waddr = fill_ff[EAW-1:0];
                  fill_in = fill_ff + EFW'(1);
                  a_in = req_data.end_a;
                  b_in = req_data.end_b;
                  deg_rea = 1'b1;  deg_raddr_a = NIW'(req_data.end_a);
                  deg_reb = 1'b1;  deg_raddr_b = NIW'(req_data.end_b);
               end
            end
         end
         ST_LD_A: begin
            deg_we = 1'b1;
            deg_waddr = NIW'(a_ff);
            deg_wdata = deg_add(deg_qa_ff, (a_ff == b_ff) ? 2'd2 : 2'd1);
         end
         ST_LD_B: begin
            deg_we = 1'b1;
            deg_waddr = NIW'(b_ff);
            deg_wdata = deg_add(deg_qb_ff, 2'd1);
         end
         ST_SCAN: begin
            if (scan_ff != '0) begin
               deg_rea = 1'b1;   deg_raddr_a = NIW'(scan_dec);
               alive_re = 1'b1;  alive_raddr = NIW'(scan_dec);
               scan_in = scan_dec;
               pend_in = 1'b1;
               pidx_in = scan_dec;
            end
            if (pend_ff && alive_q_ff && (!found_ff || deg_qa_ff < bdeg_ff)) begin
               found_in = 1'b1;
               best_in = pidx_ff;
               bdeg_in = deg_qa_ff;
            end
            if (scan_ff == '0 && !pend_ff && found_ff) begin
               size_in = size_ff + CNT_W'(1);
               alive_we = 1'b1;  alive_waddr = NIW'(best_ff);  alive_wdata = 1'b0;
               ep_in = '0;
            end
         end
         ST_SWEEP: begin
            if (ep_ff != fill_ff) begin
               edge_re = 1'b1;
               edge_raddr = ep_ff[EAW-1:0];
               ep_in = ep_ff + EFW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (ea == best_ff) begin
                  alive_we = 1'b1;  alive_waddr = NIW'(eb);
               end else if (eb == best_ff) begin
                  alive_we = 1'b1;  alive_waddr = NIW'(ea);
               end
            end
            if (ep_ff == fill_ff && !pend_ff) begin
               scan_in = live_cnt;
               found_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (out_can) begin
               out_push = 1'b1;
               fill_in = '0;
               drop_in = 1'b0;
               clr_in = '0;
            end
         end
         default: clr_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
      if (deg_rea) deg_qa_ff <= deg_mem[deg_raddr_a];
      if (deg_reb) deg_qb_ff <= deg_mem[deg_raddr_b];
      if (alive_we) alive_mem[alive_waddr] <= alive_wdata;
      if (alive_re) alive_q_ff <= alive_mem[alive_raddr];
      if (edge_we) edge_mem[edge_waddr] <= {b_in, a_in};
      if (edge_re) edge_q_ff <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         fill_ff  <= '0;
         drop_ff  <= 1'b0;
         ncnt_ff  <= CNT_W'(1024);
         pend_ff  <= 1'b0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         drop_ff  <= drop_in;
         pend_ff  <= pend_in;
         clr_ff   <= clr_in;
         if (csr_wr_en) ncnt_ff <= csr_wr_data;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      scan_ff  <= scan_in;
      pidx_ff  <= pidx_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bdeg_ff  <= bdeg_in;
      size_ff  <= size_in;
      ep_ff    <= ep_in;
   end

   gisd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .can_push  (out_can),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/greedy_independent_set_by_degree_test.sv
// Self-checking testbench for greedy_independent_set_by_degree: loads graphs edge by edge,
// predicts each finish result with a behavioral MIS builder and checks every transfer.
// Depends on gisd_pkg and the greedy_independent_set_by_degree RTL.
module greedy_independent_set_by_degree_test;
   import gisd_pkg::*;

   localparam int NODES_CAP = 1024;
   localparam int EDGES_CAP = 4096;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   greedy_independent_set_by_degree dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_sets[$];
   int errors = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int finishes = 0;

   // shadow graph state
   logic [2*ID_W-1:0] edge_mem[EDGES_CAP];
   int edge_cnt;
   logic [DEG_W-1:0] degree[NODES_CAP];
   bit alive[NODES_CAP];
   bit dropped;
   logic [CNT_W-1:0] node_count_reg;

   function automatic int eff_count();
      return (node_count_reg > NODES_CAP) ? NODES_CAP : int'(node_count_reg);
   endfunction

   function automatic void clear_graph();
      edge_cnt = 0;
      dropped = 0;
      for (int i = 0; i < NODES_CAP; i++) begin
         degree[i] = '0;
         alive[i] = 1;
      end
   endfunction

   function automatic void add_degree(int id);
      if (degree[id] < DEG_MAX) degree[id]++;
   endfunction

   function automatic int build_set();
      int cnt, size, best;
      bit found;
      logic [DEG_W-1:0] best_deg;
      int a, b;
      cnt = eff_count();
      size = 0;
      forever begin
         found = 0;
         best = 0;
         best_deg = '0;
         for (int v = cnt - 1; v >= 0; v--)
            if (alive[v] && (!found || degree[v] < best_deg)) begin
               found = 1;
               best = v;
               best_deg = degree[v];
            end
         if (!found) break;
         size++;
         alive[best] = 0;
         for (int e = 0; e < edge_cnt; e++) begin
            a = edge_mem[e][ID_W-1:0];
            b = edge_mem[e][2*ID_W-1:ID_W];
            if (a == best) alive[b] = 0;
            if (b == best) alive[a] = 0;
         end
      end
      return size;
   endfunction

   function automatic void apply_req(req_type r);
      rsp_type res;
      int cnt;
      if (r.func == FUNC_LOAD) begin
         cnt = eff_count();
         if (r.end_a >= cnt || r.end_b >= cnt || edge_cnt >= EDGES_CAP) begin
            dropped = 1;
         end else begin
            edge_mem[edge_cnt] = {r.end_b, r.end_a};
            edge_cnt++;
            add_degree(r.end_a);
            add_degree(r.end_b);
         end
      end else begin
         res.set_size = CNT_W'(build_set());
         res.dropped_edges = dropped;
         expected_sets = {expected_sets, res};
         clear_graph();
      end
   endfunction

   task automatic report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) apply_req(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_data <= pending_reqs[0];
               pending_reqs.delete(0);
               req_valid <= 1;
               items_sent++;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sets.size() == 0) begin
               report($sformatf("unexpected result size=%0d drop=%0b",
                  rsp_data.set_size, rsp_data.dropped_edges));
            end else begin
               rsp_type exp_r;
               exp_r = expected_sets[0];
               expected_sets.delete(0);
               if (rsp_data.set_size !== exp_r.set_size)
                  report($sformatf("set_size %0d, expected %0d",
                     rsp_data.set_size, exp_r.set_size));
               if (rsp_data.dropped_edges !== exp_r.dropped_edges)
                  report($sformatf("dropped_edges %0b, expected %0b",
                     rsp_data.dropped_edges, exp_r.dropped_edges));
               finishes++;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic push_edge(int a, int b);
      req_type r;
      r.func = FUNC_LOAD;
      r.end_a = ID_W'(a);
      r.end_b = ID_W'(b);
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic push_finish();
      req_type r;
      r.func = FUNC_FINISH;
      r.end_a = ID_W'($urandom);
      r.end_b = ID_W'($urandom);
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_sets.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_count(int value);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= CNT_W'(value);
      @(posedge clock);
      csr_wr_en <= 0;
      node_count_reg = CNT_W'(value);
   endtask

   initial begin
      int cnt, n_edges, a, b;
      node_count_reg = CNT_W'(1024);
      clear_graph();
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed: id extremes, self-loop, cap, mid-load count change
      push_edge(0, 1023);
      push_edge(1023, 1023);
      push_edge(5, 5);
      write_count(2047);
      push_edge(1023, 0);
      push_edge(682, 341);
      write_count(3);
      push_edge(2, 1023);
      push_edge(1, 2);
      push_edge(0, 0);
      push_finish();
      write_count(0);
      push_edge(0, 0);
      push_finish();
      write_count(1);
      push_finish();
      push_edge(0, 0);
      push_edge(0, 1);
      push_finish();
      write_count(2);
      push_edge(0, 1);
      push_edge(1, 0);
      push_finish();
      push_finish();
      // store full
      write_count(5);
      for (int i = 0; i <= EDGES_CAP; i++)
         push_edge($urandom_range(4), $urandom_range(4));
      push_finish();
      drain();

      // random graphs across idle and stall phases
      for (int g = 0; items_sent < 6000; g++) begin
         case ((g / 8) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         if ($urandom_range(3) == 0)
            write_count($urandom_range(9) == 0 ? $urandom_range(2047) % 41 : $urandom_range(1, 40));
         cnt = eff_count();
         n_edges = $urandom_range(60);
         for (int i = 0; i < n_edges; i++) begin
            if (cnt > 0 && $urandom_range(9) != 0) begin
               a = $urandom_range(cnt - 1);
               b = ($urandom_range(7) == 0) ? a : $urandom_range(cnt - 1);
            end else begin
               a = $urandom_range(1023);
               b = $urandom_range(1023);
            end
            push_edge(a, b);
         end
         push_finish();
         if (items_sent > 1800 + EDGES_CAP + 30) break;
         while (pending_reqs.size() > 40) @(posedge clock);
      end
      drain();
      repeat (2 * NODES_CAP + 100) @(posedge clock);
      $display("ran %0d request transfers, %0d set results checked, %0d errors",
         items_sent, finishes, errors);
      if (errors == 0 && expected_sets.size() == 0)
         $display("PASS greedy_independent_set_by_degree");
      else
         $display("FAIL greedy_independent_set_by_degree");
      $finish;
   end

   initial begin
      #(80_000_000);
      $display("timeout");
      $display("FAIL greedy_independent_set_by_degree");
      $finish;
   end

endmodule
